// ===== hw/rtl/vzc_pkg.sv =====
// ----------------------------------------------------------------------------
// vzc_pkg: shared types, codes and helpers for the varint / zigzag codec
// Sequencer states, action codes, byte-group constants and zigzag mapping.
// ----------------------------------------------------------------------------
package vzc_pkg;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ENC,
		ST_DEC
	} vzc_state_t;

	// Action codes carried on the action field
	localparam logic ACT_ENCODE = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	// Byte group layout
	localparam int unsigned GROUP_BITS = 7;
	localparam logic [7:0]  CONT_MASK  = 8'h80;
	localparam logic [6:0]  GROUP_MASK = 7'h7F;

	// Byte limits per value width
	localparam logic [3:0] LIMIT_NARROW = 4'd5;
	localparam logic [3:0] LIMIT_WIDE   = 4'd10;

	// Index of the last possible byte of an encoded 64-bit value
	localparam logic [3:0] ENC_LAST_IDX = 4'd9;

	// Map a value to the unsigned form that gets encoded
	function automatic logic [63:0] vzc_zz_encode(input logic [63:0] v, input logic wide);
		logic [31:0] x;
		begin
			x = v[31:0];
			if (wide) begin
				vzc_zz_encode = {v[62:0], 1'b0} ^ {64{v[63]}};
			end else begin
				vzc_zz_encode = {32'd0, {x[30:0], 1'b0} ^ {32{x[31]}}};
			end
		end
	endfunction

	// Undo the zigzag mapping; narrow results are sign-extended from bit 31
	function automatic logic [63:0] vzc_zz_decode(input logic [63:0] v, input logic wide);
		logic [31:0] r;
		begin
			r = {1'b0, v[31:1]} ^ {32{v[0]}};
			if (wide) begin
				vzc_zz_decode = {1'b0, v[63:1]} ^ {64{v[0]}};
			end else begin
				vzc_zz_decode = {{32{r[31]}}, r};
			end
		end
	endfunction

endpackage

// ===== hw/rtl/varint_zigzag_codec.sv =====
// ----------------------------------------------------------------------------
// varint_zigzag_codec: base-128 varint encoder / decoder with zigzag mapping
// One shared 64-bit shifter under a small sequencer; a new input word is taken only once the last is finished.
// ----------------------------------------------------------------------------
// Usage: an encode word (action = 0) takes value_in, zigzag-maps it when
// signed_mode is set, and returns 1 to 10 byte words, least significant
// seven-bit group first, bit 7 set on all but the final byte, which carries
// last = 1. A decode word (action = 1) takes one byte_in; its seven data bits
// are merged into an internal accumulator, and a value word (is_value = 1) is
// returned once a byte arrives with bit 7 clear or the byte limit (5 for
// 32-bit, 10 for 64-bit) is reached; hitting the limit with bit 7 still set
// raises overlong. The width and signed mode of a decode sequence are taken
// from its first byte. Encode words may be interleaved with a partly decoded
// sequence without disturbing it. Timing: in_ready is high only while the
// sequencer is idle. An encode word is accepted in the idle state and then
// emits its bytes from the encode state; the single shifter peels one
// seven-bit group per cycle while the output register can take a word. A
// decode byte is accepted in the idle state, and the shifter places its group
// in the accumulator in the decode state. A full output register stalls the
// sequencer until the waiting word is taken.
// ----------------------------------------------------------------------------
module varint_zigzag_codec
	import vzc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic        wide,
	input  logic        signed_mode,
	input  logic [63:0] value_in,
	input  logic [7:0]  byte_in,

	output logic        out_valid,
	input  logic        out_ready,
	output logic        is_value,
	output logic [7:0]  byte_out,
	output logic        last,
	output logic [63:0] value_out,
	output logic        overlong
);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	vzc_state_t  state_q, state_nxt;

	// Encode: remaining groups and count of bytes already emitted
	logic [63:0] enc_val_q;
	logic [3:0]  enc_cnt_q;

	// Decode: accumulator and sequence context
	logic [63:0] acc_q;
	logic [3:0]  dec_cnt_q;
	logic        dec_active_q;
	logic        held_wide_q;
	logic        held_signed_q;
	logic [7:0]  dec_byte_q;

	// Output register
	logic        out_valid_q;
	logic        is_value_q;
	logic [7:0]  byte_out_q;
	logic        last_q;
	logic [63:0] value_out_q;
	logic        overlong_q;

	// ------------------------------------------------------------------
	// Control
	// ------------------------------------------------------------------
	logic        in_fire;
	logic        slot_free;
	logic        enc_fire;
	logic        dec_fire;
	logic        dec_emit;

	// Shared shifter
	logic [63:0] sh_op;
	logic [5:0]  sh_amt;
	logic        sh_left;
	logic [63:0] sh_res;

	// Encode step
	logic        enc_last;
	logic [7:0]  enc_byte;

	// Decode step
	logic [6:0]  dec_shift_full;
	logic [63:0] acc_nxt;
	logic [3:0]  dec_cnt_nxt;
	logic [3:0]  dec_limit;
	logic        dec_cont;
	logic        dec_done;
	logic [63:0] dec_value;

	// ------------------------------------------------------------------
	// Next-state logic
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = (action == ACT_DECODE) ? ST_DEC : ST_ENC;
				end
			end
			ST_ENC: begin
				if (slot_free && enc_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_DEC: begin
				if (slot_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output / strobe logic
	// ------------------------------------------------------------------
	always_comb begin
		in_ready  = (state_q == ST_IDLE);
		in_fire   = in_valid && in_ready;
		// Output register can take a new word when empty or being drained
		slot_free = !out_valid_q || out_ready;
		enc_fire  = (state_q == ST_ENC) && slot_free;
		dec_fire  = (state_q == ST_DEC) && slot_free;
		dec_emit  = dec_fire && dec_done;
	end

	// ------------------------------------------------------------------
	// Shared shifter: right by one group when encoding, left by 7*count
	// when placing a decode group
	// ------------------------------------------------------------------
	assign dec_shift_full = {dec_cnt_q, 3'b000} - {3'b000, dec_cnt_q};

	always_comb begin
		if (state_q == ST_DEC) begin
			sh_op   = {57'd0, dec_byte_q[6:0] & GROUP_MASK};
			sh_amt  = dec_shift_full[5:0];
			sh_left = 1'b1;
		end else begin
			sh_op   = enc_val_q;
			sh_amt  = 6'(GROUP_BITS);
			sh_left = 1'b0;
		end
		sh_res = sh_left ? (sh_op << sh_amt) : (sh_op >> sh_amt);
	end

	// ------------------------------------------------------------------
	// Encode step: emit low group, flag continuation unless this is the end
	// ------------------------------------------------------------------
	always_comb begin
		enc_last = (enc_val_q[63:7] == 57'd0) || (enc_cnt_q == ENC_LAST_IDX);
		if (enc_last) begin
			enc_byte = enc_val_q[7:0];
		end else begin
			enc_byte = CONT_MASK | {1'b0, enc_val_q[6:0]};
		end
	end

	// ------------------------------------------------------------------
	// Decode step: merge group, drop bits above the width, check end
	// ------------------------------------------------------------------
	always_comb begin
		acc_nxt = acc_q | sh_res;
		if (!held_wide_q) begin
			acc_nxt = {32'd0, acc_nxt[31:0]};
		end
		dec_cnt_nxt = dec_cnt_q + 4'd1;
		dec_limit   = held_wide_q ? LIMIT_WIDE : LIMIT_NARROW;
		dec_cont    = (dec_byte_q & CONT_MASK) != 8'd0;
		dec_done    = !dec_cont || (dec_cnt_nxt >= dec_limit);
		dec_value   = held_signed_q ? vzc_zz_decode(acc_nxt, held_wide_q) : acc_nxt;
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			enc_cnt_q     <= 4'd0;
			acc_q         <= 64'd0;
			dec_cnt_q     <= 4'd0;
			dec_active_q  <= 1'b0;
			held_wide_q   <= 1'b0;
			held_signed_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_nxt;

			// Start a new decode sequence on its first byte only
			if (in_fire && (action == ACT_DECODE) && !dec_active_q) begin
				acc_q         <= 64'd0;
				dec_cnt_q     <= 4'd0;
				held_wide_q   <= wide;
				held_signed_q <= signed_mode;
				dec_active_q  <= 1'b1;
			end

			if (in_fire && (action == ACT_ENCODE)) begin
				enc_cnt_q <= 4'd0;
			end else if (enc_fire) begin
				enc_cnt_q <= enc_cnt_q + 4'd1;
			end

			if (dec_fire) begin
				if (dec_done) begin
					acc_q        <= 64'd0;
					dec_cnt_q    <= 4'd0;
					dec_active_q <= 1'b0;
				end else begin
					acc_q     <= acc_nxt;
					dec_cnt_q <= dec_cnt_nxt;
				end
			end

			// Drop a taken word, load a new one
			if (enc_fire || dec_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire && (action == ACT_ENCODE)) begin
			if (signed_mode) begin
				enc_val_q <= vzc_zz_encode(value_in, wide);
			end else if (wide) begin
				enc_val_q <= value_in;
			end else begin
				enc_val_q <= {32'd0, value_in[31:0]};
			end
		end else if (enc_fire) begin
			enc_val_q <= sh_res;
		end

		if (in_fire && (action == ACT_DECODE)) begin
			dec_byte_q <= byte_in;
		end

		if (enc_fire) begin
			is_value_q  <= 1'b0;
			byte_out_q  <= enc_byte;
			last_q      <= enc_last;
			value_out_q <= 64'd0;
			overlong_q  <= 1'b0;
		end else if (dec_emit) begin
			is_value_q  <= 1'b1;
			byte_out_q  <= 8'd0;
			last_q      <= 1'b0;
			value_out_q <= dec_value;
			overlong_q  <= dec_cont;
		end
	end

	assign out_valid = out_valid_q;
	assign is_value  = is_value_q;
	assign byte_out  = byte_out_q;
	assign last      = last_q;
	assign value_out = value_out_q;
	assign overlong  = overlong_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
`ifndef SYNTHESIS
	// Encoder never runs past the tenth byte
	a_enc_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ENC) |-> (enc_cnt_q <= ENC_LAST_IDX))
		else $error("encode byte count out of range");

	// An open decode sequence stays below its byte limit
	a_dec_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		dec_active_q |-> (dec_cnt_q < (held_wide_q ? LIMIT_WIDE : LIMIT_NARROW)))
		else $error("decode byte count reached limit without a result");

	// Continuation bit of an encoded byte is the inverse of last
	a_cont_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_value) |-> (byte_out[7] != last))
		else $error("continuation bit disagrees with last");

	// Sequencer stays busy after accepting a word
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("word accepted while previous still in progress");
`endif

endmodule
